### rtl/kcq_pkg.sv
// ----------------------------------------------------------------------------
// kcq_pkg
// Shared sizes, codes, link types and helpers for the color quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package kcq_pkg;

    localparam int MAX_PIXELS   = 4096;
    localparam int MAX_CLUSTERS = 8;

    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int IDX_W  = $clog2(MAX_CLUSTERS);
    localparam int KW     = IDX_W + 1;
    localparam int SUM_W  = ADDR_W + 8;
    localparam int DIST_W = 10;

    // pixel fetch, one stage per cell, one accumulate stage, one spare
    localparam int DRAIN_CYCLES = MAX_CLUSTERS + 3;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    localparam logic [3:0] RST_CLUSTER_COUNT = 4'd4;
    localparam logic [7:0] RST_MAX_ITER      = 8'd20;

    localparam logic CFG_CLUSTER_COUNT = 1'b0;
    localparam logic CFG_MAX_ITER      = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PASS,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_NEXT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [23:0]       px;
        logic [DIST_W-1:0] score;
        logic [IDX_W-1:0]  best;
    } t_link;

    typedef struct packed {
        logic             frame_clear;
        logic             seed_we;
        logic [IDX_W-1:0] seed_idx;
        logic [23:0]      seed_px;
        logic             upd_we;
        logic [IDX_W-1:0] upd_idx;
        logic [23:0]      upd_mean;
        logic             acc_clear;
    } t_cell_ctrl;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

### rtl/kcq_cell.sv
// ----------------------------------------------------------------------------
// kcq_cell
// One cluster: holds its mean, compares it against the pixel passing down
// the chain, and accumulates the members that the chain tail assigns to it.
// ----------------------------------------------------------------------------
`default_nettype none

module kcq_cell import kcq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic             i_active,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire t_link            i_link,
    input  wire t_link            i_tail,
    output t_link                 o_link,
    output logic [23:0]           o_mean,
    output logic [SUM_W-1:0]      o_sum_r,
    output logic [SUM_W-1:0]      o_sum_g,
    output logic [SUM_W-1:0]      o_sum_b,
    output logic [CNT_W-1:0]      o_count
);

    logic [23:0]       r_mean;
    t_link             r_link;
    t_link             n_link;
    logic [SUM_W-1:0]  r_sum_r, r_sum_g, r_sum_b;
    logic [CNT_W-1:0]  r_count;
    logic [DIST_W-1:0] w_dist;

    always_comb begin
        w_dist = DIST_W'(absdiff8(r_mean[23:16], i_link.px[23:16]))
               + DIST_W'(absdiff8(r_mean[15:8],  i_link.px[15:8]))
               + DIST_W'(absdiff8(r_mean[7:0],   i_link.px[7:0]));
        n_link = i_link;
        // strict compare keeps ties on the lower index
        if (i_active && (w_dist < i_link.score)) begin
            n_link.score = w_dist;
            n_link.best  = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
        end
        r_link.addr  <= n_link.addr;
        r_link.px    <= n_link.px;
        r_link.score <= n_link.score;
        r_link.best  <= n_link.best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (i_ctrl.seed_we && (i_ctrl.seed_idx == i_idx)) begin
            r_mean <= i_ctrl.seed_px;
        end else if (i_ctrl.frame_clear) begin
            r_mean <= '0;
        end else if (i_ctrl.upd_we && (i_ctrl.upd_idx == i_idx)) begin
            r_mean <= i_ctrl.upd_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.acc_clear) begin
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else if (i_tail.valid && (i_tail.best == i_idx)) begin
            r_sum_r <= r_sum_r + SUM_W'(i_tail.px[23:16]);
            r_sum_g <= r_sum_g + SUM_W'(i_tail.px[15:8]);
            r_sum_b <= r_sum_b + SUM_W'(i_tail.px[7:0]);
            r_count <= r_count + 1'b1;
        end
    end

    assign o_link  = r_link;
    assign o_mean  = r_mean;
    assign o_sum_r = r_sum_r;
    assign o_sum_g = r_sum_g;
    assign o_sum_b = r_sum_b;
    assign o_count = r_count;

endmodule

`default_nettype wire

### rtl/kcq_div.sv
// ----------------------------------------------------------------------------
// kcq_div
// Restoring divider, one quotient bit per cycle. The quotient is a channel
// average, so it always fits in eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kcq_div import kcq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0] i_den,
    output logic                  o_done,
    output logic [7:0]            o_quo
);

    logic             r_busy;
    logic [2:0]       r_step;
    logic [SUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [7:0]       r_quo;
    logic             r_done;
    logic [SUM_W+7:0] w_trial;

    assign w_trial = (SUM_W+8)'(r_den) << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd7;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                if ({8'd0, r_rem} >= w_trial) begin
                    r_rem         <= r_rem - w_trial[SUM_W-1:0];
                    r_quo[r_step] <= 1'b1;
                end
                if (r_step == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

### rtl/kmeans_color_quantizer.sv
// ----------------------------------------------------------------------------
// kmeans_color_quantizer
// Frame-based k-means color quantizer, Manhattan distance, chain of cells.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): command 0 loads one pixel per cycle
// unless stalled, with optional seed flag; a pixel with last_pixel set starts
// clustering. Command 1 reads out the next pixel's cluster and mean color, one
// readout at a time; a readout before clustering or past the frame gives no beat.
// Output channel (o_valid / i_stall): kind 0 is the summary after clustering
// (passes used, converged), kind 1 a readout pixel.
// Clustering: each pass streams the frame from the pixel memory through one
// cell per cluster, one pixel per cycle, then drains the chain and computes
// the new means one channel at a time in the shared divider. The summary
// appears after passes_used such passes. o_stall stays high while
// clustering, in the read state that follows a readout that yields a beat,
// and while a result waits under a stalled receiver.
// Reset: cluster_count 4, max_iterations 20, means zero, no frame loaded.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_color_quantizer import kcq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_command,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic       i_seed_mean,
    input  wire logic       i_last_pixel,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_kind,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic [2:0]      o_cluster_index,
    output logic [7:0]      o_passes_used,
    output logic            o_converged,
    output logic            o_final_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [3:0]         r_cc;
    logic [7:0]         r_mi;
    logic [CNT_W-1:0]   r_total;
    logic [KW-1:0]      r_seeds;
    logic [CNT_W-1:0]   r_pos;
    logic               r_frame_done;
    logic [CNT_W-1:0]   r_addr;
    logic [DRAIN_W-1:0] r_drain;
    logic [IDX_W-1:0]   r_j;
    logic [1:0]         r_c;
    logic [7:0]         r_nm [3];
    logic               r_changed;
    logic [7:0]         r_passes;
    logic [IDX_W-1:0]   r_asg_q;
    t_link              r_head;

    logic               r_ov;
    logic               r_kind;
    logic [23:0]        r_color;
    logic [2:0]         r_cidx;
    logic [7:0]         r_pused;
    logic               r_conv;
    logic               r_final;

    logic [23:0]        pix_mem [MAX_PIXELS];
    logic [IDX_W-1:0]   asg_mem [MAX_PIXELS];

    t_link              w_link [MAX_CLUSTERS+1];
    logic [23:0]        w_mean [MAX_CLUSTERS];
    logic [SUM_W-1:0]   w_sum  [MAX_CLUSTERS][3];
    logic [CNT_W-1:0]   w_cnt  [MAX_CLUSTERS];
    t_cell_ctrl         w_ctrl;

    logic               w_in_acc, w_load, w_read, w_cfg_we;
    logic [KW-1:0]      w_k;
    logic [7:0]         w_lim;
    logic [CNT_W-1:0]   w_eff_total;
    logic [KW-1:0]      w_eff_seeds;
    logic               w_skip, w_last_j, w_more, w_start_pass, w_div_start;
    logic               w_div_done;
    logic [7:0]         w_quo;
    logic [23:0]        w_nm_all;
    logic               w_rd_ok;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign o_stall     = !((r_state == ST_IDLE) && (!r_ov || !i_stall));
    assign w_in_acc    = i_valid && !o_stall;
    assign w_load      = w_in_acc && (i_command == CMD_LOAD);
    assign w_read      = w_in_acc && (i_command == CMD_READ);
    assign w_rd_ok     = r_frame_done && (r_pos < r_total);

    always_comb begin
        if (r_cc == 4'd0) begin
            w_k = KW'(1);
        end else if (KW'(r_cc) > KW'(MAX_CLUSTERS)) begin
            w_k = KW'(MAX_CLUSTERS);
        end else begin
            w_k = KW'(r_cc);
        end
    end
    assign w_lim       = (r_mi == 8'd0) ? 8'd1 : r_mi;
    assign w_eff_total = r_frame_done ? '0 : r_total;
    assign w_eff_seeds = r_frame_done ? '0 : r_seeds;
    assign w_skip      = (KW'(r_j) >= w_k) || (w_cnt[r_j] == '0);
    assign w_last_j    = (KW'(r_j) + 1'b1 >= w_k);
    assign w_more      = r_changed && ({1'b0, r_passes} + 9'd1 < {1'b0, w_lim});
    assign w_nm_all    = {r_nm[0], r_nm[1], r_nm[2]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load && i_last_pixel) begin
                    n_state = ST_PASS;
                end else if (w_read && w_rd_ok) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_IDLE;
            ST_PASS: begin
                if (r_addr + 1'b1 >= r_total) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: n_state = w_skip ? ST_NEXT : ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_c == 2'd2) ? ST_UPDATE : ST_DIV_START;
                end
            end
            ST_UPDATE: n_state = ST_NEXT;
            ST_NEXT: begin
                if (!w_last_j) begin
                    n_state = ST_DIV_START;
                end else if (w_more) begin
                    n_state = ST_PASS;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_ctrl             = '0;
        w_ctrl.frame_clear = w_load && r_frame_done;
        w_ctrl.seed_we     = w_load && i_seed_mean && (w_eff_seeds < KW'(MAX_CLUSTERS));
        w_ctrl.seed_idx    = w_eff_seeds[IDX_W-1:0];
        w_ctrl.seed_px     = {i_red, i_green, i_blue};
        w_ctrl.upd_we      = (r_state == ST_UPDATE) && (w_nm_all != w_mean[r_j]);
        w_ctrl.upd_idx     = r_j;
        w_ctrl.upd_mean    = w_nm_all;
        w_start_pass       = ((r_state == ST_IDLE) && w_load && i_last_pixel)
                          || ((r_state == ST_NEXT) && w_last_j && w_more);
        w_ctrl.acc_clear   = w_start_pass;
        w_div_start        = (r_state == ST_DIV_START) && !w_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= RST_CLUSTER_COUNT;
            r_mi <= RST_MAX_ITER;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_CLUSTER_COUNT: r_cc <= i_cfg_data[3:0];
                CFG_MAX_ITER:      r_mi <= i_cfg_data;
                default:           r_cc <= r_cc;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_load && (w_eff_total < CNT_W'(MAX_PIXELS))) begin
            pix_mem[w_eff_total[ADDR_W-1:0]] <= {i_red, i_green, i_blue};
        end
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head.valid <= (r_state == ST_PASS);
        end
        r_head.addr  <= r_addr[ADDR_W-1:0];
        r_head.px    <= pix_mem[r_addr[ADDR_W-1:0]];
        r_head.score <= '1;
        r_head.best  <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_link[MAX_CLUSTERS].valid) begin
            asg_mem[w_link[MAX_CLUSTERS].addr] <= w_link[MAX_CLUSTERS].best;
        end
        if (w_read) begin
            r_asg_q <= asg_mem[r_pos[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_seeds      <= '0;
            r_pos        <= '0;
            r_frame_done <= 1'b0;
            r_addr       <= '0;
            r_drain      <= '0;
            r_j          <= '0;
            r_c          <= '0;
            r_changed    <= 1'b0;
            r_passes     <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (w_load) begin
                r_frame_done <= 1'b0;
                r_pos        <= '0;
                if (w_eff_total < CNT_W'(MAX_PIXELS)) begin
                    r_total <= w_eff_total + 1'b1;
                end else begin
                    r_total <= w_eff_total;
                end
                r_seeds <= w_ctrl.seed_we ? w_eff_seeds + 1'b1 : w_eff_seeds;
            end
            if (w_start_pass) begin
                r_addr    <= '0;
                r_changed <= 1'b0;
                if (r_state == ST_IDLE) begin
                    r_passes <= '0;
                end
            end
            if (r_state == ST_PASS) begin
                r_addr  <= r_addr + 1'b1;
                r_drain <= '0;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= r_drain + 1'b1;
                r_j     <= '0;
                r_c     <= '0;
            end
            if ((r_state == ST_DIV_WAIT) && w_div_done) begin
                r_nm[r_c] <= w_quo;
                r_c       <= r_c + 1'b1;
            end
            if (w_ctrl.upd_we) begin
                r_changed <= 1'b1;
            end
            if (r_state == ST_NEXT) begin
                r_j <= r_j + 1'b1;
                r_c <= '0;
                if (w_last_j) begin
                    r_passes <= r_passes + 1'b1;
                    if (!w_more) begin
                        // emit the summary
                        r_ov         <= 1'b1;
                        r_kind       <= KIND_SUMMARY;
                        r_color      <= '0;
                        r_cidx       <= '0;
                        r_pused      <= r_passes + 1'b1;
                        r_conv       <= !r_changed;
                        r_final      <= 1'b0;
                        r_frame_done <= 1'b1;
                        r_pos        <= '0;
                    end
                end
            end
            if (r_state == ST_READ) begin
                r_ov    <= 1'b1;
                r_kind  <= KIND_PIXEL;
                r_color <= w_mean[r_asg_q];
                r_cidx  <= 3'(r_asg_q);
                r_pused <= '0;
                r_conv  <= 1'b0;
                r_final <= (r_pos + 1'b1 == r_total);
                r_pos   <= r_pos + 1'b1;
            end
        end
    end

    assign w_link[0] = r_head;

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        kcq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_active(KW'(g) < w_k),
            .i_ctrl  (w_ctrl),
            .i_link  (w_link[g]),
            .i_tail  (w_link[MAX_CLUSTERS]),
            .o_link  (w_link[g+1]),
            .o_mean  (w_mean[g]),
            .o_sum_r (w_sum[g][0]),
            .o_sum_g (w_sum[g][1]),
            .o_sum_b (w_sum[g][2]),
            .o_count (w_cnt[g])
        );
    end

    kcq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_sum[r_j][r_c]),
        .i_den  (w_cnt[r_j]),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    assign o_valid         = r_ov;
    assign o_kind          = r_kind;
    assign o_out_red       = r_color[23:16];
    assign o_out_green     = r_color[15:8];
    assign o_out_blue      = r_color[7:0];
    assign o_cluster_index = r_cidx;
    assign o_passes_used   = r_pused;
    assign o_converged     = r_conv;
    assign o_final_item    = r_final;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while clustering");

    a_pass_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> (r_addr < r_total))
        else $error("pass address beyond frame");

    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider result outside wait state");

    a_seed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeds <= KW'(MAX_CLUSTERS))
        else $error("seed count overflow");

endmodule

`default_nettype wire
